// ===== design/kmc_pkg.sv =====
// Shared types, codes and limits for the k-means clustering block.
`default_nettype none
package kmc_pkg;
	localparam int MAX_POINTS   = 1024;
	localparam int MAX_DIMS     = 8;
	localparam int MAX_CLUSTERS = 16;

	localparam logic [1:0] CMD_LOAD        = 2'd0;
	localparam logic [1:0] CMD_START       = 2'd1;
	localparam logic [1:0] CMD_READ_LABEL  = 2'd2;
	localparam logic [1:0] CMD_READ_CENTRE = 2'd3;

	localparam logic [1:0] KIND_DONE   = 2'd0;
	localparam logic [1:0] KIND_LABEL  = 2'd1;
	localparam logic [1:0] KIND_CENTRE = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [2:0] REG_NUM_POINTS   = 3'd0;
	localparam logic [2:0] REG_NUM_DIMS     = 3'd1;
	localparam logic [2:0] REG_NUM_CLUSTERS = 3'd2;
	localparam logic [2:0] REG_THRESHOLD    = 3'd3;
	localparam logic [2:0] REG_MAX_ITER     = 3'd4;

	localparam logic [10:0] RST_NUM_POINTS   = 11'd1024;
	localparam logic [3:0]  RST_NUM_DIMS     = 4'd8;
	localparam logic [4:0]  RST_NUM_CLUSTERS = 5'd2;
	localparam logic [15:0] RST_THRESHOLD    = 16'd3277;
	localparam logic [7:0]  RST_MAX_ITER     = 8'd255;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         point_index;
		logic [2:0]         dim_index;
		logic [3:0]         cluster_index;
		logic signed [15:0] coord_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic signed [15:0] result_value;
		logic [7:0]         iterations_used;
		logic               hit_cap;
	} out_item_t;

	// effective (saturated) run settings
	typedef struct packed {
		logic [10:0] n;
		logic [3:0]  d;
		logic [4:0]  k;
		logic [15:0] thr;
		logic [7:0]  cap;
	} run_cfg_t;
endpackage
`default_nettype wire

// ===== design/kmeans_clustering.sv =====
// Top level: configuration registers, input gating and output register.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+--------------------------
//  input   | in_valid, in_stall, in_data      | in_valid && !in_stall
//  output  | out_valid, out_stall, out_data   | out_valid && !out_stall
//  config  | cfg_write, cfg_index, cfg_data   | cfg_write
//
// A load is written into the point store as it is taken. A read passes through S_HRD and
// S_HOUT, the core result register and the output register; the next input is taken once
// that result has left. A start sets up, copies points into the centres and runs passes;
// its run time is bounded by the shared distance unit and the divider.
// After reset a sweep clears labels and centres; inputs stall meanwhile.
// in_stall stays high while a run or read is busy or a result is pending or held.
`default_nettype none
module kmeans_clustering (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire kmc_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output kmc_pkg::out_item_t      out_data,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	logic [10:0] num_points_q;
	logic [3:0]  num_dims_q;
	logic [4:0]  num_clusters_q;
	logic [15:0] threshold_q;
	logic [7:0]  max_iter_q;
	logic        out_valid_q;
	kmc_pkg::out_item_t out_q;
	kmc_pkg::run_cfg_t  run_cfg;
	kmc_pkg::out_item_t core_res;
	logic        core_idle, core_res_valid, go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q   <= kmc_pkg::RST_NUM_POINTS;
			num_dims_q     <= kmc_pkg::RST_NUM_DIMS;
			num_clusters_q <= kmc_pkg::RST_NUM_CLUSTERS;
			threshold_q    <= kmc_pkg::RST_THRESHOLD;
			max_iter_q     <= kmc_pkg::RST_MAX_ITER;
		end else if (cfg_write) begin
			case (cfg_index)
				kmc_pkg::REG_NUM_POINTS:   num_points_q   <= cfg_data[10:0];
				kmc_pkg::REG_NUM_DIMS:     num_dims_q     <= cfg_data[3:0];
				kmc_pkg::REG_NUM_CLUSTERS: num_clusters_q <= cfg_data[4:0];
				kmc_pkg::REG_THRESHOLD:    threshold_q    <= cfg_data;
				kmc_pkg::REG_MAX_ITER:     max_iter_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// saturate to store limits
	always_comb begin
		run_cfg.n   = (num_points_q > 11'(kmc_pkg::MAX_POINTS))
			? 11'(kmc_pkg::MAX_POINTS) : num_points_q;
		run_cfg.d   = (num_dims_q > 4'(kmc_pkg::MAX_DIMS)) ? 4'(kmc_pkg::MAX_DIMS) : num_dims_q;
		run_cfg.k   = (num_clusters_q > 5'(kmc_pkg::MAX_CLUSTERS))
			? 5'(kmc_pkg::MAX_CLUSTERS) : num_clusters_q;
		run_cfg.thr = threshold_q;
		run_cfg.cap = (max_iter_q == 8'd0) ? 8'd1 : max_iter_q;
	end

	// a result on its way into the output register also holds off the next item
	assign in_stall = !core_idle || out_valid_q || core_res_valid;
	assign go       = in_valid && !in_stall;

	kmc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item      (in_data),
		.cfg       (run_cfg),
		.idle      (core_idle),
		.res_valid (core_res_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid) out_q <= core_res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

// ===== design/kmc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module kmc_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [10:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	logic [31:0] quo_q;
	logic [10:0] rem_q;
	logic [10:0] div_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [11:0] rem_sh;
	logic [11:0] rem_sub;
	logic        fits;

	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign fits    = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd31;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 11'd0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? rem_sub[10:0] : rem_sh[10:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== design/kmc_core.sv =====
// Sequencer, stores and shared distance datapath for Lloyd passes.
`default_nettype none
module kmc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire kmc_pkg::in_item_t item,
	input  wire kmc_pkg::run_cfg_t cfg,
	output logic                   idle,
	output logic                   res_valid,
	output kmc_pkg::out_item_t     res
);
	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_HRD   = 5'd2;
	localparam logic [4:0] S_HOUT  = 5'd3;
	localparam logic [4:0] S_START = 5'd4;
	localparam logic [4:0] S_CPRD  = 5'd5;
	localparam logic [4:0] S_CPWR  = 5'd6;
	localparam logic [4:0] S_DRD   = 5'd7;
	localparam logic [4:0] S_DMUL  = 5'd8;
	localparam logic [4:0] S_DACC  = 5'd9;
	localparam logic [4:0] S_DCMP  = 5'd10;
	localparam logic [4:0] S_LRD   = 5'd11;
	localparam logic [4:0] S_LUPD  = 5'd12;
	localparam logic [4:0] S_SRD   = 5'd13;
	localparam logic [4:0] S_SWR   = 5'd14;
	localparam logic [4:0] S_QRD   = 5'd15;
	localparam logic [4:0] S_QLD   = 5'd16;
	localparam logic [4:0] S_QRUN  = 5'd17;
	localparam logic [4:0] S_QWR   = 5'd18;
	localparam logic [4:0] S_CONV  = 5'd19;
	localparam logic [4:0] S_CHK   = 5'd20;

	logic signed [15:0] pt_mem  [0:kmc_pkg::MAX_POINTS*kmc_pkg::MAX_DIMS-1];
	logic [4:0]         lbl_mem [0:kmc_pkg::MAX_POINTS-1];
	logic signed [15:0] cen_mem [0:kmc_pkg::MAX_CLUSTERS*kmc_pkg::MAX_DIMS-1];
	logic signed [31:0] sum_mem [0:kmc_pkg::MAX_CLUSTERS*kmc_pkg::MAX_DIMS-1];
	logic [10:0]        count_q [0:kmc_pkg::MAX_CLUSTERS-1];

	logic signed [15:0] pt_rd_q, cen_rd_q;
	logic [4:0]         lbl_rd_q;
	logic signed [31:0] sum_rd_q;

	logic [4:0]  state_q;
	logic [9:0]  clr_q;
	logic [6:0]  cp_q;
	logic [10:0] i_q;
	logic [4:0]  c_q;
	logic [3:0]  j_q;
	logic [35:0] acc_q, best_q;
	logic [3:0]  best_c_q;
	logic [33:0] sq_q;
	logic [10:0] changed_q;
	logic [7:0]  pass_q;
	logic        hitcap_q;
	logic        neg_q;
	logic [15:0] quo_q;
	logic [26:0] prod_q;
	logic        res_valid_q;
	kmc_pkg::out_item_t res_q;
	kmc_pkg::in_item_t  item_q;

	logic [12:0] pt_raddr;
	logic [6:0]  cen_raddr, sum_raddr, cen_waddr, sum_waddr;
	logic [9:0]  lbl_raddr, lbl_waddr;
	logic        cen_we, sum_we, lbl_we, pt_we;
	logic signed [15:0] cen_wdata;
	logic signed [31:0] sum_wdata;
	logic [4:0]  lbl_wdata;
	logic [3:0]  d_m1;
	logic [4:0]  k_m1;
	logic [10:0] n_m1;
	logic signed [16:0] diff;
	logic [16:0] diff_mag;
	logic        cp_in_run;
	logic        div_start, div_done;
	logic [31:0] div_quo, div_dividend;
	logic        div_entry_ok;
	logic        conv;
	logic [7:0]  pass_n;

	assign d_m1 = cfg.d - 4'd1;
	assign k_m1 = cfg.k - 5'd1;
	assign n_m1 = cfg.n - 11'd1;
	assign diff = {pt_rd_q[15], pt_rd_q} - {cen_rd_q[15], cen_rd_q};
	assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
	assign cp_in_run = ({1'b0, cp_q[6:3]} < cfg.k) && ({1'b0, cp_q[2:0]} < cfg.d);
	assign div_entry_ok = cp_in_run && (count_q[cp_q[6:3]] != 11'd0);
	assign div_start = (state_q == S_QLD) && div_entry_ok;
	assign div_dividend = sum_rd_q[31] ? 32'(-sum_rd_q) : 32'(sum_rd_q);
	assign conv = {changed_q, 16'd0} <= prod_q;
	assign pass_n = pass_q + 8'd1;

	kmc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q[cp_q[6:3]]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// memory address and write selection
	always_comb begin
		pt_we     = go && (state_q == S_IDLE) && (item.command == kmc_pkg::CMD_LOAD);
		pt_raddr  = (state_q == S_CPRD) ? {6'd0, cp_q} : {i_q[9:0], j_q[2:0]};
		cen_raddr = (state_q == S_HRD) ? {item_q.cluster_index, item_q.dim_index}
			: {c_q[3:0], j_q[2:0]};
		lbl_raddr = (state_q == S_HRD) ? item_q.point_index : i_q[9:0];
		sum_raddr = (state_q == S_SRD) ? {best_c_q, j_q[2:0]} : cp_q;
		cen_we    = 1'b0;
		cen_waddr = cp_q;
		cen_wdata = 16'sd0;
		sum_we    = 1'b0;
		sum_waddr = cp_q;
		sum_wdata = 32'sd0;
		lbl_we    = 1'b0;
		lbl_waddr = i_q[9:0];
		lbl_wdata = {1'b1, best_c_q};
		case (state_q)
			S_CLR: begin
				lbl_we    = 1'b1;
				lbl_waddr = clr_q;
				lbl_wdata = 5'd0;
				cen_we    = (clr_q[9:7] == 3'd0);
				cen_waddr = clr_q[6:0];
			end
			S_CPWR: begin
				cen_we    = 1'b1;
				cen_wdata = cp_in_run ? pt_rd_q : 16'sd0;
				sum_we    = 1'b1;
			end
			S_LUPD: lbl_we = 1'b1;
			S_SWR: begin
				sum_we    = 1'b1;
				sum_waddr = {best_c_q, j_q[2:0]};
				sum_wdata = sum_rd_q + 32'(pt_rd_q);
			end
			S_QWR: begin
				cen_we    = 1'b1;
				cen_wdata = quo_q;
				sum_we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[{item.point_index, item.dim_index}] <= item.coord_value;
		pt_rd_q <= pt_mem[pt_raddr];
		if (cen_we)
			cen_mem[cen_waddr] <= cen_wdata;
		cen_rd_q <= cen_mem[cen_raddr];
		if (lbl_we)
			lbl_mem[lbl_waddr] <= lbl_wdata;
		lbl_rd_q <= lbl_mem[lbl_raddr];
		if (sum_we)
			sum_mem[sum_waddr] <= sum_wdata;
		sum_rd_q <= sum_mem[sum_raddr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (go) item_q <= item;
			S_START, S_CHK: begin
				for (int m = 0; m < kmc_pkg::MAX_CLUSTERS; m++)
					count_q[m] <= 11'd0;
			end
			S_DMUL: sq_q <= 34'(diff_mag * diff_mag);
			S_LUPD: count_q[best_c_q] <= count_q[best_c_q] + 11'd1;
			S_QLD: begin
				neg_q <= sum_rd_q[31];
				quo_q <= 16'd0;
			end
			S_QRUN: if (div_done) quo_q <= neg_q ? 16'(-div_quo) : div_quo[15:0];
			S_CONV: prod_q <= 27'(cfg.thr * cfg.n);
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= 10'd0;
			cp_q        <= 7'd0;
			i_q         <= 11'd0;
			c_q         <= 5'd0;
			j_q         <= 4'd0;
			acc_q       <= 36'd0;
			best_q      <= 36'd0;
			best_c_q    <= 4'd0;
			changed_q   <= 11'd0;
			pass_q      <= 8'd0;
			hitcap_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 10'd1;
					if (clr_q == 10'd1023) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (go) begin
						case (item.command)
							kmc_pkg::CMD_LOAD:  state_q <= S_IDLE;
							kmc_pkg::CMD_START: state_q <= S_START;
							default:            state_q <= S_HRD;
						endcase
					end
				end
				S_HRD: state_q <= S_HOUT;
				S_HOUT: begin
					res_valid_q           <= 1'b1;
					res_q.iterations_used <= pass_q;
					res_q.hit_cap         <= hitcap_q;
					if (item_q.command == kmc_pkg::CMD_READ_LABEL) begin
						res_q.result_kind  <= kmc_pkg::KIND_LABEL;
						res_q.result_value <= lbl_rd_q[4] ? {12'd0, lbl_rd_q[3:0]} : 16'hFFFF;
					end else begin
						res_q.result_kind  <= kmc_pkg::KIND_CENTRE;
						res_q.result_value <= cen_rd_q;
					end
					state_q <= S_IDLE;
				end
				S_START: begin
					if (cfg.k == 5'd0 || cfg.n < {6'd0, cfg.k}) begin
						res_valid_q <= 1'b1;
						res_q       <= '{kmc_pkg::KIND_ERROR, 16'sd0, 8'd0, 1'b0};
						state_q     <= S_IDLE;
					end else begin
						cp_q    <= 7'd0;
						state_q <= S_CPRD;
					end
				end
				S_CPRD: state_q <= S_CPWR;
				S_CPWR: begin
					cp_q <= cp_q + 7'd1;
					if (cp_q == 7'd127) begin
						pass_q    <= 8'd0;
						i_q       <= 11'd0;
						c_q       <= 5'd0;
						j_q       <= 4'd0;
						acc_q     <= 36'd0;
						changed_q <= 11'd0;
						state_q   <= S_DRD;
					end else begin
						state_q <= S_CPRD;
					end
				end
				S_DRD: state_q <= (cfg.d == 4'd0) ? S_DCMP : S_DMUL;
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					acc_q <= acc_q + {2'd0, sq_q};
					if (j_q == d_m1) begin
						j_q     <= 4'd0;
						state_q <= S_DCMP;
					end else begin
						j_q     <= j_q + 4'd1;
						state_q <= S_DRD;
					end
				end
				S_DCMP: begin
					// strict compare keeps the lower index on a tie
					if (c_q == 5'd0 || acc_q < best_q) begin
						best_q   <= acc_q;
						best_c_q <= c_q[3:0];
					end
					acc_q <= 36'd0;
					if (c_q == k_m1) begin
						state_q <= S_LRD;
					end else begin
						c_q     <= c_q + 5'd1;
						state_q <= S_DRD;
					end
				end
				S_LRD: state_q <= S_LUPD;
				S_LUPD: begin
					// first pass of a run counts every label as changed
					if (pass_q == 8'd0 || !lbl_rd_q[4] || lbl_rd_q[3:0] != best_c_q)
						changed_q <= changed_q + 11'd1;
					j_q <= 4'd0;
					if (cfg.d != 4'd0) begin
						state_q <= S_SRD;
					end else begin
						c_q <= 5'd0;
						if (i_q == n_m1) begin
							cp_q    <= 7'd0;
							state_q <= S_QRD;
						end else begin
							i_q     <= i_q + 11'd1;
							state_q <= S_DRD;
						end
					end
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					if (j_q == d_m1) begin
						j_q <= 4'd0;
						c_q <= 5'd0;
						if (i_q == n_m1) begin
							cp_q    <= 7'd0;
							state_q <= S_QRD;
						end else begin
							i_q     <= i_q + 11'd1;
							state_q <= S_DRD;
						end
					end else begin
						j_q     <= j_q + 4'd1;
						state_q <= S_SRD;
					end
				end
				S_QRD: state_q <= S_QLD;
				S_QLD: state_q <= div_entry_ok ? S_QRUN : S_QWR;
				S_QRUN: if (div_done) state_q <= S_QWR;
				S_QWR: begin
					cp_q <= cp_q + 7'd1;
					state_q <= (cp_q == 7'd127) ? S_CONV : S_QRD;
				end
				S_CONV: state_q <= S_CHK;
				S_CHK: begin
					pass_q <= pass_n;
					if (!conv && pass_n < cfg.cap) begin
						i_q       <= 11'd0;
						c_q       <= 5'd0;
						j_q       <= 4'd0;
						acc_q     <= 36'd0;
						changed_q <= 11'd0;
						state_q   <= S_DRD;
					end else begin
						hitcap_q    <= !conv;
						res_valid_q <= 1'b1;
						res_q       <= '{kmc_pkg::KIND_DONE, 16'sd0, pass_n, !conv};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule
`default_nettype wire
